>>> src/keyed_status_table_macros.svh
// keyed_status_table_macros.svh: assertion macros for the keyed status table
// used by keyed_status_table.sv; expects clk_i and rst_ni in the including scope
`ifndef KEYED_STATUS_TABLE_MACROS_SVH
`define KEYED_STATUS_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed_status_table: same-cycle check failed");

// next-cycle implication, checked out of reset
`define KST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed_status_table: next-cycle check failed");

`endif

>>> src/kst_pkg.sv
// kst_pkg: beat types, codes, token and write structs, key helpers
// for the keyed status table; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

  localparam int unsigned KeyW     = 64;
  localparam int unsigned StatW    = 8;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned OutIdxW  = 4;
  localparam int unsigned KeyChars = 8;

  localparam logic [StatW-1:0] ActiveStatus = 8'd1;
  localparam logic [StatW-1:0] NoStatus     = 8'd0;

  typedef enum logic [1:0] {
    KstClear  = 2'd0,
    KstUpsert = 2'd1,
    KstFind   = 2'd2,
    KstQuery  = 2'd3
  } kst_mode_e;

  typedef enum logic [1:0] {
    KstOk       = 2'd0,
    KstBadStat  = 2'd1,
    KstFull     = 2'd2,
    KstNotFound = 2'd3
  } kst_code_e;

  typedef struct packed {
    kst_mode_e        mode;
    logic [KeyW-1:0]  key;
    logic [StatW-1:0] status;
  } kst_in_t;

  typedef struct packed {
    kst_code_e          result_code;
    logic [OutIdxW-1:0] entry_index;
    logic               existed;
    logic               any_active;
  } kst_out_t;

  // request travelling down the row of cells
  typedef struct packed {
    logic             vld;
    kst_mode_e        mode;
    logic [KeyW-1:0]  key;
    logic [KeyW-1:0]  fkey;
    logic [StatW-1:0] status;
    logic             hit;
    logic             empty_seen;
    logic [IdxW-1:0]  idx;
    logic             active;
  } kst_tok_t;

  // insert broadcast to the claiming cell
  typedef struct packed {
    logic             en;
    logic [KeyW-1:0]  key;
    logic [StatW-1:0] status;
  } kst_wr_t;

  function automatic logic [KeyW-1:0] normalize_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    logic            live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i >= KeyChars || k[8*i +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*i +: 8] = k[8*i +: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [KeyW-1:0] fold_case(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    logic [7:0]      b;
    r = '0;
    b = '0;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (b >= 8'h41 && b <= 8'h5A) begin
        b = b + 8'h20;
      end
      r[8*i +: 8] = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/kst_cell.sv
// kst_cell: one table entry plus one stage of the request chain
// depends on kst_pkg
`timescale 1ns / 1ps
`default_nettype none

module kst_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kst_pkg::kst_tok_t tok_i,
  input  wire kst_pkg::kst_wr_t  wr_i,
  output kst_pkg::kst_tok_t      tok_o
);

  localparam logic [kst_pkg::IdxW-1:0] IdxC = Idx[kst_pkg::IdxW-1:0];

  logic                        used_q;
  logic                        cand_q;
  logic [kst_pkg::KeyW-1:0]    key_q;
  logic [kst_pkg::StatW-1:0]   status_q;
  kst_pkg::kst_tok_t           tok_q, tok_d;

  logic                        is_ups, is_find, is_clr;
  logic                        ups_hit, find_hit, claim, act;
  logic [kst_pkg::StatW-1:0]   status_now;

  always_comb begin
    is_ups   = tok_i.vld && tok_i.mode == kst_pkg::KstUpsert
               && tok_i.status != kst_pkg::NoStatus;
    is_find  = tok_i.vld && tok_i.mode == kst_pkg::KstFind;
    is_clr   = tok_i.vld && tok_i.mode == kst_pkg::KstClear;
    ups_hit  = is_ups && used_q && !tok_i.hit
               && kst_pkg::fold_case(key_q) == tok_i.fkey;
    find_hit = is_find && used_q && !tok_i.hit && key_q == tok_i.key;
    claim    = is_ups && !used_q && !tok_i.hit && !tok_i.empty_seen;
    status_now = ups_hit ? tok_i.status : status_q;
    act      = !is_clr && used_q && status_now == kst_pkg::ActiveStatus;

    tok_d = tok_i;
    if (ups_hit || find_hit) begin
      tok_d.hit = 1'b1;
      tok_d.idx = IdxC;
    end
    if (claim) begin
      tok_d.empty_seen = 1'b1;
      tok_d.idx        = IdxC;
    end
    tok_d.active = tok_i.active | act;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      cand_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.vld) begin
        cand_q <= claim;
      end
      if (is_clr) begin
        used_q <= 1'b0;
      end else if (wr_i.en && cand_q) begin
        used_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && cand_q) begin
      key_q    <= wr_i.key;
      status_q <= wr_i.status;
    end else if (ups_hit) begin
      status_q <= tok_i.status;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

>>> src/keyed_status_table.sv
// keyed_status_table: top level, row of kst_cell entries, result stage
// depends on kst_pkg, kst_cell and keyed_status_table_macros.svh
//
//  channel | signals                             | payload
//  in      | in_valid_i / in_ready_o / in_data_i  | kst_pkg::kst_in_t
//  out     | out_valid_o / out_ready_i / out_data_o | kst_pkg::kst_out_t
//
// one beat in flight: the request walks the row through each cell's register, is held
// in the decision stage (fin_q) for the decision and insert write, and its result is then
// loaded into the output register; in_ready_o rises as the result is loaded
// reset empties every entry at once; keys and status are not cleared
// a stalled output holds the finished request in the decision stage
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_status_table_macros.svh"

module keyed_status_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire kst_pkg::kst_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output kst_pkg::kst_out_t     out_data_o
);

  kst_pkg::kst_tok_t  tok [ENTRIES+1];
  kst_pkg::kst_tok_t  tok_in;
  kst_pkg::kst_tok_t  fin_q;
  kst_pkg::kst_wr_t   wr;
  kst_pkg::kst_out_t  res, out_q;
  logic               busy_q, out_vld_q, load_out, ins;
  logic [ENTRIES:0]   tok_vld;
  logic [kst_pkg::KeyW-1:0] nkey;

  assign in_ready_o = !busy_q;

  always_comb begin
    nkey          = kst_pkg::normalize_key(in_data_i.key);
    tok_in        = '0;
    tok_in.vld    = in_valid_i && in_ready_o;
    tok_in.mode   = in_data_i.mode;
    tok_in.key    = nkey;
    tok_in.fkey   = kst_pkg::fold_case(nkey);
    tok_in.status = in_data_i.status;
  end

  assign tok[0] = tok_in;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    kst_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[g]),
      .wr_i  (wr),
      .tok_o (tok[g+1])
    );
    assign tok_vld[g] = tok[g+1].vld;
  end
  assign tok_vld[ENTRIES] = fin_q.vld;

  assign load_out = fin_q.vld && (!out_vld_q || out_ready_i);

  always_comb begin
    ins = fin_q.mode == kst_pkg::KstUpsert && fin_q.status != kst_pkg::NoStatus
          && !fin_q.hit && fin_q.empty_seen;
    wr.en     = load_out && ins;
    wr.key    = fin_q.key;
    wr.status = fin_q.status;

    res             = '0;
    res.result_code = kst_pkg::KstOk;
    res.any_active  = fin_q.active;
    unique case (fin_q.mode)
      kst_pkg::KstUpsert: begin
        if (fin_q.status == kst_pkg::NoStatus) begin
          res.result_code = kst_pkg::KstBadStat;
        end else if (fin_q.hit) begin
          res.entry_index = fin_q.idx[kst_pkg::OutIdxW-1:0];
          res.existed     = 1'b1;
        end else if (fin_q.empty_seen) begin
          res.entry_index = fin_q.idx[kst_pkg::OutIdxW-1:0];
          res.any_active  = fin_q.active | (fin_q.status == kst_pkg::ActiveStatus);
        end else begin
          res.result_code = kst_pkg::KstFull;
        end
      end
      kst_pkg::KstFind: begin
        if (fin_q.hit) begin
          res.entry_index = fin_q.idx[kst_pkg::OutIdxW-1:0];
        end else begin
          res.result_code = kst_pkg::KstNotFound;
        end
      end
      kst_pkg::KstClear: begin
        res.any_active = 1'b0;
      end
      kst_pkg::KstQuery: begin
        res.any_active = fin_q.active;
      end
      default: begin
        res.result_code = kst_pkg::KstOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q     <= '0;
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (tok[ENTRIES].vld) begin
        fin_q <= tok[ENTRIES];
      end else if (load_out) begin
        fin_q.vld <= 1'b0;
      end
      if (tok[0].vld) begin
        busy_q <= 1'b1;
      end else if (load_out) begin
        busy_q <= 1'b0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `KST_ASSERT_NOW(a_fin_busy, fin_q.vld, busy_q)
  `KST_ASSERT_NOW(a_one_request, 1'b1, $onehot0(tok_vld))
  `KST_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, busy_q)
  `KST_ASSERT_NEXT(a_insert_out, wr.en, out_vld_q && !busy_q)

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench: self-checking bench for keyed_status_table, one file
// depends on kst_pkg and the keyed_status_table rtl; holds its own table model
// directed corner beats first, then random upsert/find/query/clear traffic with idles and a long stall
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TableSlots  = 16;
  localparam int unsigned RandomBeats = 880;
  localparam int unsigned PoolSize    = 24;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned TailCycles  = 40;

  class kst_table_model;
    bit                slot_used[TableSlots];
    bit [63:0]         slot_key[TableSlots];
    bit [7:0]          slot_stat[TableSlots];
    kst_pkg::kst_out_t reply_q[$];
    int                errors;
    int                replies;
    int                hits;
    int                code_seen[4];

    // keep bytes up to the first zero byte
    function bit [63:0] trim_key(bit [63:0] k);
      bit [63:0] r;
      r = '0;
      for (int i = 0; i < kst_pkg::KeyChars; i++) begin
        if (k[8*i +: 8] == 8'h00) break;
        r[8*i +: 8] = k[8*i +: 8];
      end
      return r;
    endfunction

    function bit [63:0] lower_ascii(bit [63:0] k);
      bit [63:0] r;
      r = k;
      for (int i = 0; i < 8; i++) begin
        if (k[8*i +: 8] inside {[8'h41:8'h5A]}) r[8*i + 5] = 1'b1;
      end
      return r;
    endfunction

    function int pending();
      return reply_q.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void note_request(kst_pkg::kst_in_t req);
      kst_pkg::kst_out_t exp;
      bit [63:0]         k;
      bit [63:0]         fk;
      int                slot;
      exp = '0;
      exp.result_code = kst_pkg::KstOk;
      k = trim_key(req.key);
      slot = -1;
      case (req.mode)
        kst_pkg::KstClear: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
        end
        kst_pkg::KstUpsert: begin
          if (req.status == kst_pkg::NoStatus) begin
            exp.result_code = kst_pkg::KstBadStat;
          end else begin
            fk = lower_ascii(k);
            for (int i = 0; i < TableSlots; i++) begin
              if (slot_used[i] && lower_ascii(slot_key[i]) == fk) begin
                slot = i;
                break;
              end
            end
            if (slot >= 0) begin
              slot_stat[slot] = req.status;
              exp.existed = 1'b1;
            end else begin
              for (int i = 0; i < TableSlots; i++) begin
                if (!slot_used[i]) begin
                  slot = i;
                  break;
                end
              end
              if (slot >= 0) begin
                slot_used[slot] = 1'b1;
                slot_key[slot]  = k;
                slot_stat[slot] = req.status;
              end else begin
                exp.result_code = kst_pkg::KstFull;
              end
            end
          end
        end
        kst_pkg::KstFind: begin
          exp.result_code = kst_pkg::KstNotFound;
          for (int i = 0; i < TableSlots; i++) begin
            if (slot_used[i] && slot_key[i] == k) begin
              slot = i;
              exp.result_code = kst_pkg::KstOk;
              break;
            end
          end
        end
        default: ;
      endcase
      if (slot >= 0) exp.entry_index = 4'(slot);
      foreach (slot_used[i]) begin
        if (slot_used[i] && slot_stat[i] == kst_pkg::ActiveStatus) exp.any_active = 1'b1;
      end
      reply_q.push_back(exp);
    endfunction

    function void check_reply(kst_pkg::kst_out_t got);
      kst_pkg::kst_out_t exp;
      if (reply_q.size() == 0) begin
        flag($sformatf("reply with nothing pending: code %0d index %0d existed %0d act %0d",
                       got.result_code, got.entry_index, got.existed, got.any_active));
        return;
      end
      exp = reply_q.pop_front();
      replies++;
      code_seen[int'(exp.result_code)]++;
      if (exp.existed) hits++;
      if (got.result_code !== exp.result_code || got.entry_index !== exp.entry_index ||
          got.existed !== exp.existed || got.any_active !== exp.any_active) begin
        flag($sformatf("reply %0d: exp code/index/existed/active %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       replies, exp.result_code, exp.entry_index, exp.existed, exp.any_active,
                       got.result_code, got.entry_index, got.existed, got.any_active));
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  kst_pkg::kst_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  kst_pkg::kst_out_t out_data_o;

  kst_table_model table_model = new();
  logic [63:0]    key_pool[PoolSize];
  int             sent_count = 0;
  int             stall_left = 0;
  bit             hold_off   = 1'b0;
  bit             no_gaps    = 1'b0;

  keyed_status_table #(
    .ENTRIES(TableSlots)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // reply side: random stall per beat, long hold-off when asked
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      table_model.check_reply(out_data_o);
      stall_left <= no_gaps ? 0 : $urandom_range(0, 17);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= !hold_off && stall_left == 0;
  end

  initial begin : long_stall
    wait (sent_count >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input kst_pkg::kst_in_t req);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    table_model.note_request(req);
    sent_count++;
    @(negedge clk_i);
  endtask

  function automatic kst_pkg::kst_in_t mk(kst_pkg::kst_mode_e mode, logic [63:0] key,
                                          logic [7:0] status);
    kst_pkg::kst_in_t r;
    r.mode   = mode;
    r.key    = key;
    r.status = status;
    return r;
  endfunction

  function automatic logic [63:0] ascii_key(string s);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 8; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  function automatic logic [63:0] random_word();
    logic [63:0] r;
    int          len;
    r   = '0;
    len = ($urandom_range(0, 4) == 0) ? 8 : $urandom_range(1, 7);
    for (int i = 0; i < len; i++) r[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
    return r;
  endfunction

  function automatic logic [63:0] vary_case(logic [63:0] k);
    logic [7:0] b;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if ((b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) && $urandom_range(0, 1)) b ^= 8'h20;
      k[8*i +: 8] = b;
    end
    return k;
  endfunction

  // garbage after the terminator must be ignored
  function automatic logic [63:0] junk_tail(logic [63:0] k);
    int stop;
    stop = 8;
    for (int i = 7; i >= 0; i--) begin
      if (k[8*i +: 8] == 8'h00) stop = i;
    end
    for (int i = stop + 1; i < 8; i++) k[8*i +: 8] = 8'($urandom_range(0, 255));
    return k;
  endfunction

  function automatic logic [7:0] random_status();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return kst_pkg::NoStatus;
    if (r < 6) return kst_pkg::ActiveStatus;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic kst_pkg::kst_in_t random_request();
    int          pick;
    logic [63:0] k;
    pick = $urandom_range(0, 99);
    k    = key_pool[$urandom_range(0, PoolSize - 1)];
    if (pick < 2) return mk(kst_pkg::KstClear, {$urandom, $urandom}, 8'($urandom));
    if (pick < 50) begin
      if ($urandom_range(0, 9) < 3) k = vary_case(k);
      if ($urandom_range(0, 9) < 2) k = junk_tail(k);
      return mk(kst_pkg::KstUpsert, k, random_status());
    end
    if (pick < 85) begin
      case ($urandom_range(0, 19)) inside
        [0:4]:   k = vary_case(k);
        [5:7]:   k = junk_tail(k);
        [8:9]:   k = {$urandom, $urandom};
        default: ;
      endcase
      return mk(kst_pkg::KstFind, k, 8'($urandom));
    end
    if (pick < 92) return mk(kst_pkg::KstQuery, {$urandom, $urandom}, 8'($urandom));
    return mk(kst_pkg::kst_mode_e'($urandom_range(0, 3)), {$urandom, $urandom}, 8'($urandom));
  endfunction

  initial begin : stimulus
    int directed;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, zero status, case-insensitive update, exact find
    send_request(mk(kst_pkg::KstQuery, '1, '1));
    send_request(mk(kst_pkg::KstFind, ascii_key("abc"), 8'h00));
    send_request(mk(kst_pkg::KstUpsert, ascii_key("abc"), kst_pkg::NoStatus));
    send_request(mk(kst_pkg::KstUpsert, ascii_key("abc"), kst_pkg::ActiveStatus));
    send_request(mk(kst_pkg::KstUpsert, ascii_key("ABC"), 8'hFF));
    send_request(mk(kst_pkg::KstFind, ascii_key("ABC"), 8'h00));
    send_request(mk(kst_pkg::KstFind, 64'hFFEE_DDCC_0000_0000 | ascii_key("abc"), 8'hFF));
    // empty key and all-ones key
    send_request(mk(kst_pkg::KstUpsert, 64'h0, kst_pkg::ActiveStatus));
    send_request(mk(kst_pkg::KstUpsert, '1, 8'h80));
    send_request(mk(kst_pkg::KstFind, '1, 8'h00));
    // fill the table, then miss on a full table and hit on a full table
    for (int i = 0; i < 13; i++) begin
      send_request(mk(kst_pkg::KstUpsert, ascii_key($sformatf("k%02d", i)), 8'(i + 2)));
    end
    send_request(mk(kst_pkg::KstUpsert, ascii_key("zz"), kst_pkg::ActiveStatus));
    send_request(mk(kst_pkg::KstUpsert, ascii_key("K05"), kst_pkg::ActiveStatus));
    send_request(mk(kst_pkg::KstClear, '1, '1));
    send_request(mk(kst_pkg::KstQuery, 64'h0, 8'h00));
    directed = sent_count;

    foreach (key_pool[i]) key_pool[i] = random_word();
    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 75 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_request(random_request());
    end
    in_valid_i <= 1'b0;

    while (table_model.pending() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d beats (%0d directed), checked %0d replies, %0d upsert hits",
             sent_count, directed, table_model.replies, table_model.hits);
    $display("codes: ok %0d, bad status %0d, full %0d, not found %0d; one %0d-cycle hold-off",
             table_model.code_seen[kst_pkg::KstOk], table_model.code_seen[kst_pkg::KstBadStat],
             table_model.code_seen[kst_pkg::KstFull],
             table_model.code_seen[kst_pkg::KstNotFound], HoldCycles);
    if (table_model.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/kst_pkg.sv
src/kst_cell.sv
src/keyed_status_table.sv
dv/testbench.sv
